// ----- rtl/core/mrc_pkg.sv -----
// ============================================================================
// Mixed-radix converter package
// Shared types, register indexes and sizing constants of the index converter.
// ============================================================================
package mrc_pkg;

   localparam int NumCoords     = 4;
   localparam int CoordW        = 16;
   localparam int LinW          = 32;
   localparam int TopW          = $clog2(NumCoords);
   localparam int DimsW         = 3;
   localparam int CsrIdxW       = 3;
   localparam int StepBits      = 4;
   localparam int StepsPerDiv   = LinW / StepBits;
   localparam int NumDivs       = NumCoords - 1;
   localparam int DivStages     = NumDivs * StepsPerDiv;
   localparam logic [DimsW-1:0] MaxDims = 3'd4;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_DIMS = 3'd0,
      CSR_EXT0 = 3'd1,
      CSR_EXT1 = 3'd2,
      CSR_EXT2 = 3'd3,
      CSR_EXT3 = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_JOIN  = 1'b0,
      OP_SPLIT = 1'b1
   } op_type;

   // derived view of the configuration registers
   typedef struct packed {
      logic [NumCoords-1:0][CoordW-1:0] ext;
      logic [NumDivs-1:0][CoordW-1:0]   div;
      logic [DimsW-1:0]                 eff_dims;
      logic [TopW-1:0]                  top;
      logic                             zero_ext;
   } cfg_type;

   // one word in flight
   typedef struct packed {
      op_type                           op;
      logic                             err;
      logic [TopW-1:0]                  top;
      logic [LinW-1:0]                  n;
      logic [CoordW-1:0]                r;
      logic [NumCoords-1:0][CoordW-1:0] c;
   } item_type;

   typedef struct packed {
      op_type                           op;
      logic [LinW-1:0]                  linear;
      logic [NumCoords-1:0][CoordW-1:0] coord;
      logic                             err;
   } res_type;

endpackage

// ----- rtl/core/mrc_cfg.sv -----
// ============================================================================
// Mixed-radix converter configuration
// Register file for dimension count and extents, plus derived divisors.
// ============================================================================
module mrc_cfg
   import mrc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CoordW-1:0]  csr_data,
   output cfg_type            cfg
);

   logic [DimsW-1:0]                 dims_ff;
   logic [NumCoords-1:0][CoordW-1:0] ext_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= DimsW'(1);
         for (int d = 0; d < NumCoords; d++) begin
            ext_ff[d] <= CoordW'(1);
         end
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DIMS: dims_ff   <= csr_data[DimsW-1:0];
            CSR_EXT0: ext_ff[0] <= csr_data;
            CSR_EXT1: ext_ff[1] <= csr_data;
            CSR_EXT2: ext_ff[2] <= csr_data;
            CSR_EXT3: ext_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [DimsW-1:0] eff;
      if (dims_ff == '0) begin
         eff = DimsW'(1);
      end else if (dims_ff > MaxDims) begin
         eff = MaxDims;
      end else begin
         eff = dims_ff;
      end
      cfg.ext      = ext_ff;
      cfg.eff_dims = eff;
      cfg.top      = TopW'(eff - DimsW'(1));
      cfg.zero_ext = 1'b0;
      for (int d = 0; d < NumCoords; d++) begin
         if (DimsW'(d) < eff && ext_ff[d] == '0) begin
            cfg.zero_ext = 1'b1;
         end
      end
      // divide by one at and above the top dimension: quotient passes, remainder is zero
      for (int d = 0; d < NumDivs; d++) begin
         cfg.div[d] = (TopW'(d) < cfg.top) ? ext_ff[d] : CoordW'(1);
      end
   end

endmodule

// ----- rtl/core/mrc_pipe.sv -----
// ============================================================================
// Mixed-radix converter pipeline
// Horner multiply-add stages and radix-16 restoring division stages.
// ============================================================================
module mrc_pipe
   import mrc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   input  cfg_type  cfg,
   output logic     out_valid,
   input  logic     out_ready,
   output res_type  out_res
);

   localparam int LastStage = DivStages;

   item_type st_ff [0:LastStage];
   item_type st_in [0:LastStage];
   logic     v_ff  [0:LastStage];
   logic     adv   [0:LastStage+1];
   res_type  res_ff;
   res_type  res_in;
   logic     res_v_ff;

   function automatic item_type div_step(input item_type it, input logic [CoordW-1:0] dv);
      item_type        o;
      logic [CoordW:0] r2;
      o = it;
      for (int b = 0; b < StepBits; b++) begin
         r2  = {o.r, o.n[LinW-1]};
         o.n = {o.n[LinW-2:0], 1'b0};
         if (r2 >= {1'b0, dv}) begin
            r2     = r2 - {1'b0, dv};
            o.n[0] = 1'b1;
         end
         o.r = r2[CoordW-1:0];
      end
      return o;
   endfunction

   // bubble-collapsing advance chain
   assign adv[LastStage+1] = !res_v_ff || out_ready;
   for (genvar k = 0; k <= LastStage; k++) begin : g_adv
      assign adv[k] = !v_ff[k] || adv[k+1];
   end
   assign in_ready = adv[0];
   assign st_in[0] = in_item;

   for (genvar k = 1; k <= LastStage; k++) begin : g_stage
      localparam int D      = (k - 1) / StepsPerDiv;
      localparam bit FinDiv = ((k - 1) % StepsPerDiv) == (StepsPerDiv - 1);
      localparam int Dim    = (k <= NumCoords) ? NumCoords - k : 0;
      always_comb begin
         logic [LinW+CoordW-1:0] prod;
         item_type               nxt;
         prod = '0;
         nxt  = st_ff[k-1];
         if (st_ff[k-1].op == OP_SPLIT) begin
            nxt = div_step(st_ff[k-1], cfg.div[D]);
            if (FinDiv) begin
               nxt.c[D] = nxt.r;
               nxt.r    = '0;
            end
         end else if (k <= NumCoords) begin
            // fold one coordinate in, slowest dimension first
            prod  = st_ff[k-1].n * cfg.ext[Dim];
            nxt.n = prod[LinW-1:0] + {{(LinW-CoordW){1'b0}}, st_ff[k-1].c[Dim]};
         end
         st_in[k] = nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LastStage; k++) begin
            v_ff[k] <= 1'b0;
         end
         res_v_ff <= 1'b0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k <= LastStage; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
         if (adv[LastStage+1]) begin
            res_v_ff <= v_ff[LastStage];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= LastStage; k++) begin
         if (adv[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
      if (adv[LastStage+1]) begin
         res_ff <= res_in;
      end
   end

   // result formatting
   always_comb begin
      item_type          last;
      logic [CoordW-1:0] sat;
      last   = st_ff[LastStage];
      sat    = (|last.n[LinW-1:CoordW]) ? '1 : last.n[CoordW-1:0];
      res_in = '0;
      res_in.op = last.op;
      if (last.op == OP_JOIN) begin
         res_in.linear = last.n;
         res_in.err    = last.err;
      end else begin
         res_in.err = cfg.zero_ext ||
                      (last.n >= {{(LinW-CoordW){1'b0}}, cfg.ext[last.top]});
         if (!cfg.zero_ext) begin
            for (int d = 0; d < NumCoords; d++) begin
               if (TopW'(d) < last.top) begin
                  res_in.coord[d] = last.c[d];
               end else if (TopW'(d) == last.top) begin
                  res_in.coord[d] = sat;
               end
            end
         end
      end
   end

   assign out_valid = res_v_ff;
   assign out_res   = res_ff;

endmodule

// ----- rtl/core/mixed_radix_index_converter_top.sv -----
// ============================================================================
// Mixed-radix index converter
// Grid coordinate to linear index and back, dimension 0 varying fastest.
// ============================================================================
// Takes one word per clock while the result side does not stall, and returns
// one result word per word, in order. The pipeline depth is set by the index
// split: three chained 32-by-16 restoring divisions (by extent 0, 1 and 2),
// four quotient bits per stage, 24 stages, behind an input stage and followed
// by an output register. A join (op 0) runs a four-step Horner multiply-add in
// the first stages and then rides along. Stalls collapse bubbles, so words
// keep entering while a result waits.
// Configuration writes are always taken; write only while no word is in flight.
module mixed_radix_index_converter_top
   import mrc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CoordW-1:0]  csr_data,
   // request stream
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [95:0]        req_tdata,  // linear_in, coord_in_0..coord_in_3
   input  logic               req_tuser,  // op
   // response stream
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [95:0]        rsp_tdata,  // linear_out, coord_out_0..coord_out_3
   output logic               rsp_tuser   // range_error
);

   cfg_type  cfg;
   item_type in_item;
   res_type  res;

   mrc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // mask unused coordinates, flag out-of-range join coordinates up front
   always_comb begin
      logic [CoordW-1:0] cv;
      in_item     = '0;
      in_item.op  = op_type'(req_tuser);
      in_item.top = cfg.top;
      in_item.n   = (in_item.op == OP_SPLIT) ? req_tdata[LinW-1:0] : '0;
      for (int d = 0; d < NumCoords; d++) begin
         cv = req_tdata[LinW + d*CoordW +: CoordW];
         if (DimsW'(d) < cfg.eff_dims) begin
            in_item.c[d] = cv;
            if (in_item.op == OP_JOIN && cv >= cfg.ext[d]) begin
               in_item.err = 1'b1;
            end
         end
      end
   end

   mrc_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (in_item),
      .cfg       (cfg),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (res)
   );

   assign rsp_tdata = {res.coord[3], res.coord[2], res.coord[1], res.coord[0], res.linear};
   assign rsp_tuser = res.err;

   // a join never reports coordinates
   a_join_coords_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res.op == OP_JOIN |-> res.coord == '0)
      else $error("join result carries coordinates");

   // a split never reports a linear index
   a_split_linear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res.op == OP_SPLIT |-> res.linear == '0)
      else $error("split result carries a linear index");

   // an empty grid always flags a split and zeroes its coordinates
   a_empty_grid_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res.op == OP_SPLIT && cfg.zero_ext |-> rsp_tuser && res.coord == '0)
      else $error("split on empty grid not flagged");

endmodule
